// ----- rtl/availability_quantile_estimator_core_defines.svh -----
// Assertion macros for the availability quantile estimator.
// No dependencies.
`ifndef AVAILABILITY_QUANTILE_ESTIMATOR_CORE_DEFINES_SVH
`define AVAILABILITY_QUANTILE_ESTIMATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define AQE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AQE_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AQE_ASSERT(label, clk, rst, prop, msg)
`define AQE_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/aqe_pkg.sv -----
// Package for the availability quantile estimator: command/status types and codes.
// No dependencies.
`default_nettype none
package aqe_pkg;
  localparam logic [1:0] MODE_RECLAIM = 2'd0;
  localparam logic [1:0] MODE_AVAIL   = 2'd1;
  localparam logic [1:0] MODE_REFRESH = 2'd2;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_CONF   = 2'd1;
  localparam logic [1:0] REG_MAXS   = 2'd2;
  localparam logic [1:0] REG_BIRTH  = 2'd3;

  localparam logic [16:0] CONF_ONE = 17'd65536;
  localparam logic [17:0] CONF_TWO = 18'd131072;

  typedef struct packed {
    logic load;        // latch request
    logic clr_scan;    // index <= 0
    logic inc;         // index++
    logic ins_setup;   // hold insert position, point at top of tail
    logic shift_wr;    // move read word up one slot, step pointers down
    logic wr_new;      // write new length at insert position
    logic close;       // commit reclaim state
    logic open;        // commit open state
    logic halve_init;  // read pointer 1, write pointer 0
    logic halve_wr;    // copy odd entry down
    logic set_halve;   // commit halved count
    logic calc_idx;    // compute quantile product
    logic set_k;       // index <= quantile address
    logic est_fall;    // fallback multiply
    logic fall_take;   // commit fallback estimate
    logic est_take;    // take RAM word as estimate
    logic div_start;
    logic finish;      // result valid
  } aqe_cmd_t;

  typedef struct packed {
    logic scan_end;    // index reached count
    logic data_le;     // ram data <= length
    logic data_lt;     // ram data < idle
    logic pos_last;    // insert position beyond last slot
    logic shift_done;  // tail moved
    logic halve_due;
    logic open_period;
    logic div_done;
  } aqe_sts_t;
endpackage
`default_nettype wire

// ----- rtl/aqe_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module aqe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/aqe_ctrl.sv -----
// Controller state machine for the estimator; sequences datapath commands.
// Depends on aqe_pkg and availability_quantile_estimator_core_defines.svh.
`default_nettype none
`include "availability_quantile_estimator_core_defines.svh"
module aqe_ctrl import aqe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_fire,
  input  wire logic     enable,
  input  wire logic [1:0] mode,
  input  wire logic     out_busy,
  input  aqe_sts_t      sts,
  output aqe_cmd_t      cmd,
  output logic          idle
);
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_OPEN  = 5'd2;
  localparam logic [4:0] S_IRD   = 5'd3;
  localparam logic [4:0] S_ICMP  = 5'd4;
  localparam logic [4:0] S_IDEC  = 5'd5;
  localparam logic [4:0] S_SHRD  = 5'd6;
  localparam logic [4:0] S_SHW   = 5'd7;
  localparam logic [4:0] S_INS   = 5'd8;
  localparam logic [4:0] S_HRD   = 5'd9;
  localparam logic [4:0] S_HWR   = 5'd10;
  localparam logic [4:0] S_ERD   = 5'd11;
  localparam logic [4:0] S_ECMP  = 5'd12;
  localparam logic [4:0] S_QIDX  = 5'd13;
  localparam logic [4:0] S_QADR  = 5'd14;
  localparam logic [4:0] S_QRD   = 5'd15;
  localparam logic [4:0] S_QTAKE = 5'd16;
  localparam logic [4:0] S_FALL  = 5'd17;
  localparam logic [4:0] S_DIV   = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        state_next = S_DISP;
      end
      S_DISP: begin
        cmd.clr_scan = 1'b1;
        if (!enable) state_next = S_DONE;
        else if (mode == MODE_RECLAIM)
          state_next = sts.open_period ? S_IRD : S_DONE;
        else if (mode == MODE_AVAIL)
          state_next = sts.open_period ? S_DONE : S_OPEN;
        else if (mode == MODE_REFRESH) state_next = S_ERD;
        else state_next = S_DONE;
      end
      S_OPEN: begin
        cmd.open = 1'b1;
        if (sts.halve_due) begin
          cmd.halve_init = 1'b1;
          state_next = S_HRD;
        end else state_next = S_ERD;
      end
      // insertion: find position (RAM word valid the cycle after the address)
      S_IRD: state_next = sts.scan_end ? S_IDEC : S_ICMP;
      S_ICMP: begin
        if (sts.data_le) begin
          cmd.inc = 1'b1;
          state_next = S_IRD;
        end else state_next = S_IDEC;
      end
      S_IDEC: begin
        if (sts.pos_last) state_next = S_DIV;
        else begin
          cmd.ins_setup = 1'b1;
          state_next = S_SHRD;
        end
      end
      // shift tail up one slot, from the top down
      S_SHRD: state_next = sts.shift_done ? S_INS : S_SHW;
      S_SHW: begin
        cmd.shift_wr = 1'b1;
        state_next = S_SHRD;
      end
      S_INS: begin
        cmd.wr_new = 1'b1;
        state_next = S_DIV;
      end
      // halving: copy odd entries down
      S_HRD: begin
        if (sts.scan_end) begin
          cmd.set_halve = 1'b1;
          state_next = S_ERD;
        end else state_next = S_HWR;
      end
      S_HWR: begin
        cmd.halve_wr = 1'b1;
        state_next = S_HRD;
      end
      // estimate: skip short entries
      S_ERD: begin
        if (!sts.open_period) state_next = S_DIV;
        else if (sts.scan_end) state_next = S_QIDX;
        else state_next = S_ECMP;
      end
      S_ECMP: begin
        if (sts.data_lt) begin
          cmd.inc = 1'b1;
          state_next = S_ERD;
        end else state_next = S_QIDX;
      end
      S_QIDX: begin
        if (sts.scan_end) begin
          cmd.est_fall = 1'b1;
          state_next = S_FALL;
        end else begin
          cmd.calc_idx = 1'b1;
          state_next = S_QADR;
        end
      end
      S_QADR: begin
        cmd.set_k = 1'b1;
        state_next = S_QRD;
      end
      S_QRD: state_next = S_QTAKE;
      S_QTAKE: begin
        cmd.est_take = 1'b1;
        state_next = S_DIV;
      end
      S_FALL: begin
        cmd.fall_take = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (mode == MODE_RECLAIM) cmd.close = 1'b1;
        else cmd.div_start = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.div_done && !out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign idle = (state == S_IDLE);

  `AQE_ASSERT(a_one_load, clk, rst, cmd.load |=> state == S_DISP, "load not followed by dispatch")
  `AQE_ASSERT(a_fin_idle, clk, rst, cmd.finish |=> idle, "finish must return to idle")
  `AQE_ASSERT(a_no_wr_clash, clk, rst, $onehot0({cmd.shift_wr, cmd.wr_new, cmd.halve_wr}), "two RAM writes at once")
endmodule
`default_nettype wire

// ----- rtl/aqe_dp.sv -----
// Datapath: state registers, sorted store RAM, quantile multiply, serial divider.
// Depends on aqe_pkg and aqe_ram.
`default_nettype none
module aqe_dp import aqe_pkg::*; #(
  parameter int MAX_SAMPLES = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  aqe_cmd_t         cmd,
  output aqe_sts_t         sts,
  input  wire logic [31:0] now,
  input  wire logic [16:0] confidence,
  input  wire logic [7:0]  max_samples,
  input  wire logic [31:0] birth_time,
  output logic             available,
  output logic [31:0]      estimate,
  output logic [31:0]      last_interval,
  output logic [16:0]      avail_fraction,
  output logic [$clog2(MAX_SAMPLES+1)-1:0] count_out
);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_SAMPLES);

  logic [31:0]    now_q, pstart, last_len, total, cur_est;
  logic           open_p;
  logic [16:0]    frac;
  logic [CW-1:0]  cnt, idx, wptr, pos, top_init, lim;
  logic [31:0]    rdata, wdata, span;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [16:0]    c_eff, one_minus;
  logic [17:0]    two_minus;
  logic [32:0]    tsum, idle_num;
  logic [CW+16:0] qprod;
  logic [CW:0]    qk_w;
  logic [CW-1:0]  qk;
  logic [49:0]    fprod;
  // serial divider: (num<<16)/den, 49-bit quotient, 1 bit per cycle
  logic [48:0]    dv_num;
  logic [32:0]    dv_rem;
  logic [31:0]    dv_den;
  logic [5:0]     dv_cnt;
  logic           dv_busy;
  logic [33:0]    rem_sh, rem_sub;
  logic [48:0]    q_final;

  // elapsed: period or idle length, clamped at zero
  assign span = (now_q >= pstart) ? now_q - pstart : 32'd0;
  assign tsum = 33'(total) + 33'(span);
  assign idle_num = open_p ? tsum : 33'(total);

  assign c_eff     = (confidence > CONF_ONE) ? CONF_ONE : confidence;
  assign one_minus = CONF_ONE - c_eff;
  assign two_minus = CONF_TWO - 18'(c_eff);

  assign lim = (16'(max_samples) > 16'(MAX_SAMPLES)) ? CAP : CW'(max_samples);
  // a full store drops its largest entry
  assign top_init = (cnt >= CAP) ? CAP - CW'(1) : cnt;

  // quantile address: skipped count plus index, clamped to the last entry
  assign qk_w = {1'b0, idx} + (CW+1)'(qprod >> 16);
  assign qk   = (qk_w >= {1'b0, cnt}) ? cnt - CW'(1) : qk_w[CW-1:0];

  always_comb begin
    we    = cmd.shift_wr | cmd.wr_new | cmd.halve_wr;
    waddr = wptr[AW-1:0];
    wdata = rdata;
    if (cmd.wr_new) begin
      waddr = pos[AW-1:0];
      wdata = span;
    end
  end

  aqe_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(idx[AW-1:0]), .rdata(rdata)
  );

  assign rem_sh  = {dv_rem, dv_num[48]};
  assign rem_sub = rem_sh - {2'b00, dv_den};
  assign q_final = {dv_num[47:0], ~rem_sub[33]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; pstart <= '0; open_p <= 1'b0; last_len <= '0;
      total <= '0; cur_est <= '0; frac <= '0; dv_busy <= 1'b0;
    end else begin
      if (cmd.load) now_q <= now;
      if (cmd.clr_scan) idx <= '0;
      if (cmd.inc) idx <= idx + CW'(1);
      if (cmd.ins_setup) begin
        pos <= idx; wptr <= top_init; idx <= top_init - CW'(1);
      end
      if (cmd.shift_wr) begin
        wptr <= wptr - CW'(1); idx <= idx - CW'(1);
      end
      if (cmd.wr_new) cnt <= (cnt >= CAP) ? CAP : cnt + CW'(1);
      if (cmd.close) begin
        last_len <= span;
        total <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
        open_p <= 1'b0; pstart <= '0; cur_est <= '0;
      end
      if (cmd.open) begin
        pstart <= now_q; open_p <= 1'b1;
      end
      if (cmd.halve_init) begin
        idx <= CW'(1); wptr <= '0;
      end
      if (cmd.halve_wr) begin
        wptr <= wptr + CW'(1); idx <= idx + CW'(2);
      end
      if (cmd.set_halve) begin
        cnt <= wptr; idx <= '0;
      end
      if (cmd.calc_idx) qprod <= (CW+17)'(cnt - idx) * (CW+17)'(one_minus);
      if (cmd.set_k) idx <= qk;
      if (cmd.est_fall) fprod <= 50'(span) * 50'(two_minus);
      if (cmd.fall_take) cur_est <= (fprod[49:48] != 2'b00) ? 32'hFFFF_FFFF : fprod[47:16];
      if (cmd.est_take) cur_est <= rdata;
      if (cmd.div_start) begin
        if (now_q <= birth_time) begin
          frac <= CONF_ONE;
        end else begin
          dv_num <= {idle_num, 16'd0};
          dv_den <= now_q - birth_time;
          dv_rem <= '0; dv_cnt <= 6'd49; dv_busy <= 1'b1;
        end
      end else if (dv_busy) begin
        dv_rem <= rem_sub[33] ? rem_sh[32:0] : rem_sub[32:0];
        dv_num <= q_final;
        dv_cnt <= dv_cnt - 6'd1;
        if (dv_cnt == 6'd1) begin
          dv_busy <= 1'b0;
          frac <= (q_final > 49'd65536) ? CONF_ONE : q_final[16:0];
        end
      end
    end
  end

  assign sts.scan_end    = (idx >= cnt);
  assign sts.data_le     = (rdata <= span);
  assign sts.data_lt     = (rdata < span);
  assign sts.pos_last    = (idx >= CAP);
  assign sts.shift_done  = (wptr <= pos);
  assign sts.halve_due   = (cnt >= lim);
  assign sts.open_period = open_p;
  assign sts.div_done    = !dv_busy;

  assign available      = open_p;
  assign estimate       = open_p ? cur_est : 32'd0;
  assign last_interval  = last_len;
  assign avail_fraction = frac;
  assign count_out      = cnt;
endmodule
`default_nettype wire

// ----- rtl/availability_quantile_estimator_core.sv -----
// The sorted-store walks (halving then skip scan, or a full skip scan) and the bit-serial
// divider set how long a request takes.
// Throughput: one request at a time; the next is taken the cycle after the result is
// registered, and a result held by out_stall keeps the controller waiting.
// Reset (rst, synchronous): empty store, no open period, enable 1, confidence 52429.
`default_nettype none
module availability_quantile_estimator_core import aqe_pkg::*; #(
  parameter int MAX_SAMPLES = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] now,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             available,
  output logic [31:0]      estimate,
  output logic [31:0]      last_interval,
  output logic [16:0]      avail_fraction,
  output logic [7:0]       sample_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // configuration registers
  logic        enable;
  logic [16:0] confidence;
  logic [7:0]  max_samples;
  logic [31:0] birth_time;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1; confidence <= 17'd52429; max_samples <= 8'd100; birth_time <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE: enable      <= cfg_data[0];
        REG_CONF:   confidence  <= cfg_data[16:0];
        REG_MAXS:   max_samples <= cfg_data[7:0];
        REG_BIRTH:  birth_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  aqe_cmd_t cmd;
  aqe_sts_t sts;
  logic     idle;
  logic [CW-1:0] cnt;
  logic [1:0] mode_q;
  logic dp_avail;
  logic [31:0] dp_est, dp_last;
  logic [16:0] dp_frac;

  // a request enters only while the controller waits
  assign in_stall = !idle;
  logic in_fire;
  assign in_fire = in_valid && !in_stall;

  // mode steers the controller; the datapath latches the time itself
  always_ff @(posedge clk) begin
    if (in_fire) mode_q <= mode;
  end

  aqe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .enable(enable), .mode(mode_q),
    .out_busy(out_valid && out_stall), .sts(sts), .cmd(cmd), .idle(idle)
  );

  aqe_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .now(now),
    .confidence(confidence), .max_samples(max_samples), .birth_time(birth_time),
    .available(dp_avail), .estimate(dp_est), .last_interval(dp_last),
    .avail_fraction(dp_frac), .count_out(cnt)
  );

  // output register: result waits here while the far side stalls
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (cmd.finish) begin
      available <= dp_avail; estimate <= dp_est; last_interval <= dp_last;
      avail_fraction <= dp_frac; sample_count <= 8'(cnt);
    end
  end
endmodule
`default_nettype wire
